// ===== rtl/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

  // Width of the configuration registers and of the configuration data port.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd6;
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 16'd250;

  // Raw command codes as they arrive on the command field.
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;
  localparam logic [2:0] CMD_CHECK_ACK = 3'd5;
  localparam logic [2:0] CMD_SEND_ACK = 3'd6;

  // Decoded operation; the unused code folds into OP_NONE.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ,
    OP_CHECK_ACK,
    OP_SEND_ACK
  } op_t;

  // Bus phase of the bit engine.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_LO,
    PH_WR_HI,
    PH_RD_LO,
    PH_RD_HI,
    PH_AK_LO,
    PH_AK_HI,
    PH_CK_LO,
    PH_CK_HI,
    PH_CK_WAIT
  } phase_t;

  // One queued tick: decoded operation plus its operands and the SDA sample.
  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       give_ack;
    logic       sda_sample;
  } item_t;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  function automatic op_t decode_cmd(input logic [2:0] cmd);
    op_t op;
    unique case (cmd)
      CMD_START:     op = OP_START;
      CMD_STOP:      op = OP_STOP;
      CMD_WRITE:     op = OP_WRITE;
      CMD_READ:      op = OP_READ;
      CMD_CHECK_ACK: op = OP_CHECK_ACK;
      CMD_SEND_ACK:  op = OP_SEND_ACK;
      default:       op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cm_front.sv =====
`default_nettype none

module i2cm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    command,
  input  wire logic [7:0]    tx_byte,
  input  wire logic          give_ack,
  input  wire logic          sda_sample,
  output logic               q_valid,
  output i2cm_pkg::item_t    q_item,
  input  wire logic          q_pop
);
  import i2cm_pkg::*;

  // Two-entry queue; the stall comes straight from the fill count.
  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: decode_cmd(command), tx_byte: tx_byte,
                         give_ack: give_ack, sda_sample: sda_sample};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cm_back.sv =====
`default_nettype none

module i2cm_back #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [i2cm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          q_valid,
  input  wire i2cm_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               scl_level,
  output logic                               sda_level,
  output logic                               sda_drive,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [7:0]                         rx_byte,
  output logic                               ack_missing
);
  import i2cm_pkg::*;

  localparam int LW = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;
  localparam logic [LW-1:0] CNT_MAX = LW'((64'd1 << COUNTER_WIDTH) - 64'd1);

  logic [CFG_W-1:0]          half_period;
  logic [CFG_W-1:0]          ack_timeout;
  logic [LW-1:0]             hp_ext;
  logic [LW-1:0]             at_ext;
  logic [COUNTER_WIDTH-1:0]  hp_lim;
  logic [COUNTER_WIDTH-1:0]  at_lim;

  phase_t                    phase, phase_next;
  logic [COUNTER_WIDTH-1:0]  tick_count, tick_count_next, tick_inc;
  logic [COUNTER_WIDTH-1:0]  wait_count, wait_count_next;
  logic [3:0]                bit_index, bit_index_next, bit_inc;
  logic [7:0]                shift_reg, shift_reg_next;
  logic                      scl_reg, scl_reg_next;
  logic                      sda_reg, sda_reg_next;
  logic                      sda_en_reg, sda_en_reg_next;
  logic [1:0]                ack_flags, ack_flags_next;
  logic [7:0]                rx_hold, rx_hold_next;
  logic                      done_reg;

  logic                      counting;
  logic                      phase_done;
  logic                      bit_last;
  logic                      wait_hit;
  logic                      sda_in;
  op_t                       op;

  assign hp_ext = LW'(half_period);
  assign at_ext = LW'(ack_timeout);
  assign hp_lim = (hp_ext > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH-1:0] : hp_ext[COUNTER_WIDTH-1:0];
  assign at_lim = (at_ext > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH-1:0] : at_ext[COUNTER_WIDTH-1:0];

  assign sda_in     = q_item.sda_sample;
  assign op         = q_item.op;
  assign counting   = (phase != PH_IDLE) && (phase != PH_CK_WAIT);
  assign tick_inc   = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign phase_done = (tick_inc >= hp_lim);
  assign bit_inc    = bit_index + 4'd1;
  assign bit_last   = (bit_inc >= BITS_PER_BYTE);
  assign wait_hit   = (wait_count >= at_lim);

  // The engine state doubles as the output register: it only moves on a pop,
  // and a pop only happens when the output slot is free or being taken.
  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        unique case (op)
          OP_START:     phase_next = PH_ST_A;
          OP_STOP:      phase_next = PH_SP_A;
          OP_WRITE:     phase_next = PH_WR_LO;
          OP_READ:      phase_next = PH_RD_LO;
          OP_CHECK_ACK: phase_next = PH_CK_LO;
          OP_SEND_ACK:  phase_next = PH_AK_LO;
          default:      phase_next = PH_IDLE;
        endcase
      end
      PH_CK_WAIT: begin
        if (!sda_in) begin
          phase_next = PH_IDLE;
        end else if (wait_hit) begin
          phase_next = PH_SP_A;
        end
      end
      default: begin
        if (phase_done) begin
          unique case (phase)
            PH_ST_A:  phase_next = PH_ST_B;
            PH_ST_B:  phase_next = PH_IDLE;
            PH_SP_A:  phase_next = PH_SP_B;
            PH_SP_B:  phase_next = PH_IDLE;
            PH_WR_LO: phase_next = PH_WR_HI;
            PH_WR_HI: phase_next = bit_last ? PH_IDLE : PH_WR_LO;
            PH_RD_LO: phase_next = PH_RD_HI;
            PH_RD_HI: phase_next = bit_last ? PH_AK_LO : PH_RD_LO;
            PH_AK_LO: phase_next = PH_AK_HI;
            PH_AK_HI: phase_next = PH_IDLE;
            PH_CK_LO: phase_next = PH_CK_HI;
            PH_CK_HI: phase_next = PH_CK_WAIT;
            default:  phase_next = PH_IDLE;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    wait_count_next = wait_count;
    bit_index_next  = bit_index;
    shift_reg_next  = shift_reg;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_en_reg_next = sda_en_reg;
    ack_flags_next  = ack_flags;
    rx_hold_next    = rx_hold;

    // Every phase change restarts the half-period count.
    if (phase_next != phase) begin
      tick_count_next = '0;
    end else if (counting) begin
      tick_count_next = tick_inc;
    end else begin
      tick_count_next = tick_count;
    end

    unique case (phase)
      PH_IDLE: begin
        unique case (op)
          OP_START: begin
            sda_en_reg_next = 1'b1;
            scl_reg_next    = 1'b1;
            sda_reg_next    = 1'b1;
          end
          OP_STOP: begin
            sda_en_reg_next = 1'b1;
            sda_reg_next    = 1'b0;
            scl_reg_next    = 1'b1;
          end
          OP_WRITE: begin
            shift_reg_next  = q_item.tx_byte;
            bit_index_next  = 4'd0;
            scl_reg_next    = 1'b0;
            sda_en_reg_next = 1'b1;
            sda_reg_next    = q_item.tx_byte[7];
          end
          OP_READ: begin
            shift_reg_next    = 8'd0;
            bit_index_next    = 4'd0;
            ack_flags_next[1] = q_item.give_ack;
            scl_reg_next      = 1'b0;
            sda_en_reg_next   = 1'b0;
          end
          OP_CHECK_ACK: begin
            ack_flags_next[0] = 1'b0;
            scl_reg_next      = 1'b0;
          end
          OP_SEND_ACK: begin
            ack_flags_next[1] = q_item.give_ack;
            scl_reg_next      = 1'b0;
            sda_en_reg_next   = 1'b1;
            sda_reg_next      = !q_item.give_ack;
          end
          default: begin
          end
        endcase
      end
      PH_CK_WAIT: begin
        if (!sda_in) begin
          scl_reg_next = 1'b0;
        end else if (wait_hit) begin
          // No acknowledge in time: flag it and release the bus with a stop.
          ack_flags_next[0] = 1'b1;
          sda_en_reg_next   = 1'b1;
          sda_reg_next      = 1'b0;
          scl_reg_next      = 1'b1;
        end else begin
          wait_count_next = (wait_count == '1) ? wait_count : wait_count + 1'b1;
        end
      end
      default: begin
        if (phase_done) begin
          unique case (phase)
            PH_ST_A:  sda_reg_next = 1'b0;
            PH_ST_B:  scl_reg_next = 1'b0;
            PH_SP_A:  sda_reg_next = 1'b1;
            PH_WR_LO: scl_reg_next = 1'b1;
            PH_WR_HI: begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_index_next = bit_inc;
              scl_reg_next   = 1'b0;
              if (!bit_last) begin
                sda_reg_next = shift_reg[6];
              end
            end
            PH_RD_LO: begin
              scl_reg_next   = 1'b1;
              shift_reg_next = {shift_reg[6:0], sda_in};
            end
            PH_RD_HI: begin
              bit_index_next = bit_inc;
              scl_reg_next   = 1'b0;
              if (bit_last) begin
                rx_hold_next    = shift_reg;
                sda_en_reg_next = 1'b1;
                sda_reg_next    = !ack_flags[1];
              end
            end
            PH_AK_LO: scl_reg_next = 1'b1;
            PH_AK_HI: scl_reg_next = 1'b0;
            PH_CK_LO: begin
              sda_en_reg_next = 1'b0;
              scl_reg_next    = 1'b1;
            end
            PH_CK_HI: wait_count_next = '0;
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
      phase       <= PH_IDLE;
      tick_count  <= '0;
      wait_count  <= '0;
      bit_index   <= 4'd0;
      shift_reg   <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      sda_en_reg  <= 1'b1;
      ack_flags   <= 2'b00;
      rx_hold     <= 8'd0;
      done_reg    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HALF_PERIOD) begin
          half_period <= cfg_data;
        end else if (cfg_index == CFG_ACK_TIMEOUT) begin
          ack_timeout <= cfg_data;
        end
      end
      if (!out_valid || !out_stall) begin
        out_valid <= q_valid;
      end
      if (q_pop) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        wait_count <= wait_count_next;
        bit_index  <= bit_index_next;
        shift_reg  <= shift_reg_next;
        scl_reg    <= scl_reg_next;
        sda_reg    <= sda_reg_next;
        sda_en_reg <= sda_en_reg_next;
        ack_flags  <= ack_flags_next;
        rx_hold    <= rx_hold_next;
        done_reg   <= (phase != PH_IDLE) && (phase_next == PH_IDLE);
      end
    end
  end

  assign scl_level   = scl_reg;
  assign sda_level   = sda_reg;
  assign sda_drive   = sda_en_reg;
  assign busy_res    = (phase != PH_IDLE);
  assign done_res    = done_reg;
  assign rx_byte     = rx_hold;
  assign ack_missing = ack_flags[0];

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// A word accepted into the queue is registered there; it enters the engine's state registers,
// and so reaches the outputs, when it is popped, which happens only while the output slot is
// free or being taken. Throughput: one word per clock cycle while the output is not stalled.
// A two-word queue and the engine's own state registers separate the two channels.
// Reset is synchronous and active high: the bus lines go to idle high with SDA driven,
// the phase goes idle, and the registers return to half period 6 and ACK timeout 250.
`default_nettype none

module i2c_master_bit_engine #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [i2cm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    command,
  input  wire logic [7:0]                    tx_byte,
  input  wire logic                          give_ack,
  input  wire logic                          sda_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               scl_level,
  output logic                               sda_level,
  output logic                               sda_drive,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [7:0]                         rx_byte,
  output logic                               ack_missing
);
  import i2cm_pkg::*;

  // Each input word is one bus tick. The front side decodes the command and
  // parks the word in a two-entry queue, so it keeps taking words while the
  // output side is stalled, until both entries are full.
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .tx_byte    (tx_byte),
    .give_ack   (give_ack),
    .sda_sample (sda_sample),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // The back side advances the bus phase by one tick per popped word. Its
  // state registers are the result word, so a popped tick lands directly in
  // the output slot and is held there until the downstream side takes it.
  i2cm_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_level   (scl_level),
    .sda_level   (sda_level),
    .sda_drive   (sda_drive),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_missing (ack_missing)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // The engine is built with its default 16-bit counters, so both registers
  // reach the counter limit exactly at their largest value.
  localparam int COUNTER_WIDTH = 16;
  localparam int COUNT_MAX = (1 << COUNTER_WIDTH) - 1;

  // The one command code that the package does not name; the engine must ignore it.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // A slave ACK delay that no wait can reach, so the check always times out.
  localparam int NEVER_ACK = COUNT_MAX + 1;

  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  // A word is registered in the queue and then in the engine, so a few cycles of quiet after
  // the last result are enough before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 4;

  // Random traffic is spread over several timing settings, about this many words in total.
  localparam int RANDOM_WORDS = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           command;
  logic [7:0]           tx_byte;
  logic                 give_ack;
  logic                 sda_sample;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 scl_level;
  logic                 sda_level;
  logic                 sda_drive;
  logic                 busy_res;
  logic                 done_res;
  logic [7:0]           rx_byte;
  logic                 ack_missing;

  i2c_master_bit_engine #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .tx_byte(tx_byte),
    .give_ack(give_ack),
    .sda_sample(sda_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .sda_drive(sda_drive),
    .busy_res(busy_res),
    .done_res(done_res),
    .rx_byte(rx_byte),
    .ack_missing(ack_missing)
  );

  // One result word: the bus lines and status flags after a tick.
  typedef struct {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       missing;
  } line_state_t;

  // Line states still owed by the engine, oldest first.
  line_state_t lines_due[$];
  line_state_t want;

  // Our own copy of the engine: bus phase, counters, shifter and line drive.
  phase_t     eng_phase;
  int         eng_ticks;
  logic [3:0] eng_bit;
  logic [7:0] eng_shift;
  int         eng_wait;
  logic       eng_scl;
  logic       eng_sda;
  logic       eng_drive;
  logic       eng_missing;
  logic       eng_ack_latch;
  logic [7:0] eng_rx;
  logic       eng_done;

  // Our copy of the two timing registers.
  int cfg_half;
  int cfg_ack_to;

  // What the simulated slave does: the byte it returns on reads, and after how
  // many wait ticks it pulls SDA low for an ACK.
  logic [7:0] slave_byte;
  int         ack_delay;

  int words_sent;
  int results_checked;
  int commands_issued;
  int ack_timeouts;
  int mismatches;
  int burst_left;
  int quiet_cycles;
  int stall_left;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Engine prediction
  // ---------------------------------------------------------------------------

  function automatic int saturate(input int v);
    return (v > COUNT_MAX) ? COUNT_MAX : v;
  endfunction

  function automatic void enter(input phase_t p);
    eng_phase = p;
    eng_ticks = 0;
  endfunction

  function automatic void complete();
    eng_phase = PH_IDLE;
    eng_ticks = 0;
    eng_done = 1'b1;
  endfunction

  // A STOP starts with SDA driven low under a high SCL, then SDA is driven high.
  function automatic void start_stop();
    enter(PH_SP_A);
    eng_drive = 1'b1;
    eng_sda = 1'b0;
    eng_scl = 1'b1;
  endfunction

  // The ACK bit drives SDA low for an ACK and high for a NACK.
  function automatic void start_ack_bit();
    enter(PH_AK_LO);
    eng_scl = 1'b0;
    eng_drive = 1'b1;
    eng_sda = ~eng_ack_latch;
  endfunction

  // Moves our engine copy through one tick and returns the line state it shows.
  function automatic line_state_t engine_tick(input logic [2:0] cmd, input logic [7:0] tx,
                                              input logic ack, input logic sda_in);
    line_state_t r;
    eng_done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      // Commands are only taken while idle; anything else on the field is dropped.
      if (cmd != CMD_NONE && cmd != CMD_UNUSED) commands_issued++;
      case (cmd)
        CMD_START: begin
          enter(PH_ST_A);
          eng_drive = 1'b1;
          eng_scl = 1'b1;
          eng_sda = 1'b1;
        end
        CMD_STOP: start_stop();
        CMD_WRITE: begin
          eng_shift = tx;
          eng_bit = '0;
          enter(PH_WR_LO);
          eng_scl = 1'b0;
          eng_drive = 1'b1;
          eng_sda = tx[7];
        end
        CMD_READ: begin
          eng_shift = '0;
          eng_bit = '0;
          eng_ack_latch = ack;
          enter(PH_RD_LO);
          eng_scl = 1'b0;
          eng_drive = 1'b0;
        end
        CMD_CHECK_ACK: begin
          eng_missing = 1'b0;
          enter(PH_CK_LO);
          eng_scl = 1'b0;
        end
        CMD_SEND_ACK: begin
          eng_ack_latch = ack;
          start_ack_bit();
        end
        default: ;
      endcase
    end else if (eng_phase == PH_CK_WAIT) begin
      // Waiting for the slave: a low SDA ends the check, a long high one gives up.
      if (!sda_in) begin
        eng_scl = 1'b0;
        complete();
      end else if (eng_wait >= cfg_ack_to) begin
        eng_missing = 1'b1;
        ack_timeouts++;
        start_stop();
      end else begin
        eng_wait = saturate(eng_wait + 1);
      end
    end else begin
      // Timed phases: a zero half period behaves like a one-tick phase.
      eng_ticks = saturate(eng_ticks + 1);
      if (eng_ticks >= cfg_half) begin
        case (eng_phase)
          PH_ST_A: begin
            enter(PH_ST_B);
            eng_sda = 1'b0;
          end
          PH_ST_B: begin
            eng_scl = 1'b0;
            complete();
          end
          PH_SP_A: begin
            enter(PH_SP_B);
            eng_sda = 1'b1;
          end
          PH_SP_B: complete();
          PH_WR_LO: begin
            enter(PH_WR_HI);
            eng_scl = 1'b1;
          end
          PH_WR_HI: begin
            eng_shift = eng_shift << 1;
            eng_bit = eng_bit + 4'd1;
            eng_scl = 1'b0;
            if (eng_bit >= BITS_PER_BYTE) begin
              complete();
            end else begin
              enter(PH_WR_LO);
              eng_sda = eng_shift[7];
            end
          end
          PH_RD_LO: begin
            // Read data is sampled on the tick where SCL goes high.
            enter(PH_RD_HI);
            eng_scl = 1'b1;
            eng_shift = {eng_shift[6:0], sda_in};
          end
          PH_RD_HI: begin
            eng_bit = eng_bit + 4'd1;
            if (eng_bit >= BITS_PER_BYTE) begin
              eng_rx = eng_shift;
              start_ack_bit();
            end else begin
              enter(PH_RD_LO);
              eng_scl = 1'b0;
            end
          end
          PH_AK_LO: begin
            enter(PH_AK_HI);
            eng_scl = 1'b1;
          end
          PH_AK_HI: begin
            eng_scl = 1'b0;
            complete();
          end
          PH_CK_LO: begin
            enter(PH_CK_HI);
            eng_drive = 1'b0;
            eng_scl = 1'b1;
          end
          PH_CK_HI: begin
            enter(PH_CK_WAIT);
            eng_wait = 0;
          end
          default: enter(PH_IDLE);
        endcase
      end
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.drive = eng_drive;
    r.busy = (eng_phase != PH_IDLE);
    r.done = eng_done;
    r.rx = eng_rx;
    r.missing = eng_missing;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one tick word and waits until the engine takes it. The sender runs
  // in bursts; between bursts valid drops for a few cycles, and sometimes a
  // burst follows the last one with no gap at all.
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                           input logic sda);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    tx_byte <= tx;
    give_ack <= ack;
    sda_sample <= sda;
    do @(posedge clk); while (in_stall);
    lines_due.push_back(engine_tick(cmd, tx, ack, sda));
    words_sent++;
  endtask

  // Issues one command and keeps ticking until our engine copy is idle again.
  // While the engine is busy the command field carries stray codes, which it
  // must ignore, including on the tick where the command completes. SDA plays
  // the slave: the read byte MSB first, and an ACK after ack_delay wait ticks.
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack);
    logic       sda;
    logic [2:0] stray;
    send_word(cmd, tx, ack, 1'($urandom_range(0, 1)));
    while (eng_phase != PH_IDLE) begin
      if (eng_phase == PH_RD_LO) sda = slave_byte[7 - eng_bit];
      else if (eng_phase == PH_CK_WAIT) sda = (eng_wait < ack_delay);
      else sda = 1'($urandom_range(0, 1));
      stray = $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : CMD_NONE;
      send_word(stray, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
    end
  endtask

  // Waits until every owed line state has come back, lets the engine settle,
  // and then writes both timing registers on consecutive edges.
  task automatic set_timing(input int half, input int ack_to);
    in_valid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_data <= 16'(half);
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data <= 16'(ack_to);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_half = half;
    cfg_ack_to = ack_to;
  endtask

  // Slave ACK timing for random traffic: mostly inside the window, sometimes
  // right on its last tick or just past it, and sometimes never.
  function automatic int pick_ack_delay();
    case ($urandom_range(0, 6))
      0: return cfg_ack_to;
      1: return cfg_ack_to + 1;
      2: return NEVER_ACK;
      default: return $urandom_range(0, cfg_ack_to);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the bus sits high with SDA driven; empty ticks and the
  // unused command code must leave it that way.
  task automatic test_idle_after_reset();
    send_word(CMD_NONE, 8'h00, 1'b0, 1'b0);
    send_word(CMD_NONE, 8'hFF, 1'b1, 1'b1);
    send_word(CMD_UNUSED, 8'hFF, 1'b1, 1'b1);
    send_word(CMD_UNUSED, 8'h00, 1'b0, 1'b0);
  endtask

  // A full transfer at the reset timing: an all-ones write byte and both read byte extremes.
  task automatic test_reset_timing();
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b0);
    ack_delay = 0;
    run_command(CMD_CHECK_ACK, 8'h00, 1'b0);
    slave_byte = 8'h00;
    run_command(CMD_READ, 8'h00, 1'b1);
    slave_byte = 8'hFF;
    run_command(CMD_READ, 8'hFF, 1'b0);
    run_command(CMD_STOP, 8'h00, 1'b0);
  endtask

  // Every command with zero timing: one-tick phases, and an ACK timeout on the
  // very first high wait tick, which must send a STOP by itself.
  task automatic test_zero_timing();
    set_timing(0, 0);
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b0);
    ack_delay = NEVER_ACK;
    run_command(CMD_CHECK_ACK, 8'hFF, 1'b1);
    slave_byte = 8'h5A;
    run_command(CMD_READ, 8'h00, 1'b0);
    run_command(CMD_SEND_ACK, 8'h00, 1'b1);
    run_command(CMD_SEND_ACK, 8'hFF, 1'b0);
    ack_delay = 0;
    run_command(CMD_CHECK_ACK, 8'h00, 1'b0);
    run_command(CMD_STOP, 8'hFF, 1'b1);
    run_command(CMD_UNUSED, 8'hA5, 1'b1);
  endtask

  // The edge of the ACK window: an ACK on the last allowed tick is taken,
  // one tick later is too late.
  task automatic test_ack_window();
    set_timing(1, 3);
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h80, 1'b0);
    ack_delay = 3;
    run_command(CMD_CHECK_ACK, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h01, 1'b0);
    ack_delay = 4;
    run_command(CMD_CHECK_ACK, 8'h00, 1'b0);
  endtask

  // The widest ACK window: a slave that answers after a short wait must still
  // end the check with an ACK and no STOP.
  task automatic test_counter_limits();
    set_timing(1, COUNT_MAX);
    ack_delay = $urandom_range(1, 30);
    run_command(CMD_CHECK_ACK, 8'h00, 1'b0);
  endtask

  // Random traffic under several timings. Most of it is well-formed transfers
  // with random bytes, ACK choices and slave behavior; the rest is loose
  // commands in any order, which the engine must also handle.
  task automatic test_random_traffic();
    int halves[6] = '{1, 2, 0, 3, 1, 6};
    int windows[6] = '{0, 3, 12, 1, 40, 250};
    int stop_at;
    for (int s = 0; s < 6; s++) begin
      set_timing(halves[s], windows[s]);
      stop_at = words_sent + RANDOM_WORDS / 6;
      while (words_sent < stop_at) begin
        if ($urandom_range(0, 4) != 0) begin
          run_command(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          ack_delay = pick_ack_delay();
          run_command(CMD_CHECK_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) begin
              run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
              ack_delay = pick_ack_delay();
              run_command(CMD_CHECK_ACK, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
              slave_byte = 8'($urandom_range(0, 255));
              run_command(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
          end
          if ($urandom_range(0, 9) != 0)
            run_command(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          slave_byte = 8'($urandom_range(0, 255));
          ack_delay = pick_ack_delay();
          run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------

  // The receiver stalls on its own schedule: stretches of random length,
  // each with its own stall rate, several of them with no stall.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 300);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 20;
        3: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
    end
  endtask

  // Every word the engine hands over is compared with the oldest owed state.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (lines_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word arrived with none outstanding", $time);
      end else begin
        want = lines_due.pop_front();
        results_checked++;
        check_field("scl_level", 8'(want.scl), 8'(scl_level));
        check_field("sda_level", 8'(want.sda), 8'(sda_level));
        check_field("sda_drive", 8'(want.drive), 8'(sda_drive));
        check_field("busy_res", 8'(want.busy), 8'(busy_res));
        check_field("done_res", 8'(want.done), 8'(done_res));
        check_field("rx_byte", want.rx, rx_byte);
        check_field("ack_missing", 8'(want.missing), 8'(ack_missing));
      end
    end
  end

  // Hang detection: too long without a word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still owed", $time,
               HANG_LIMIT, lines_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_data <= '0;
    in_valid <= 1'b0;
    command <= CMD_NONE;
    tx_byte <= '0;
    give_ack <= 1'b0;
    sda_sample <= 1'b1;

    // Our engine copy starts from the reset state: idle bus, lines high and driven.
    eng_phase = PH_IDLE;
    eng_ticks = 0;
    eng_bit = '0;
    eng_shift = '0;
    eng_wait = 0;
    eng_scl = 1'b1;
    eng_sda = 1'b1;
    eng_drive = 1'b1;
    eng_missing = 1'b0;
    eng_ack_latch = 1'b0;
    eng_rx = '0;
    eng_done = 1'b0;
    cfg_half = int'(HALF_PERIOD_RST);
    cfg_ack_to = int'(ACK_TIMEOUT_RST);
    slave_byte = '0;
    ack_delay = 0;
    words_sent = 0;
    results_checked = 0;
    commands_issued = 0;
    ack_timeouts = 0;
    mismatches = 0;
    burst_left = 0;
    quiet_cycles = 0;
    stall_left = 0;
    stall_pct = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_after_reset();
    test_reset_timing();
    test_zero_timing();
    test_ack_window();
    test_counter_limits();
    test_random_traffic();

    // Let the last results drain, then allow a few quiet cycles for strays.
    in_valid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Run sent %0d tick words and checked %0d results over %0d bus commands,",
             words_sent, results_checked, commands_issued);
    $display("with %0d ACK timeouts, half periods from 0 to 6 and ACK windows from 0 to %0d ticks.",
             ack_timeouts, COUNT_MAX);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine.sv
verif/testbench.sv
